// ===== sv/lbs_pkg.sv =====
// Package for the LED blink sequencer: widths, phase, request kind and register index codes, reset values.
// No dependencies; every other file refers to it by scoped names.
package lbs_pkg;

    localparam int KIND_W    = 3;
    localparam int PHASE_W   = 3;
    localparam int COUNT_W   = 9;
    localparam int REG_IDX_W = 3;

    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_START = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BRK   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET   = 3'd4;

    localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PRE   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ON    = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BREAK = 3'd3;
    localparam logic [PHASE_W-1:0] PH_POST  = 3'd4;

    localparam logic [COUNT_W-1:0] ENDLESS = 9'd256;

    localparam logic [REG_IDX_W-1:0] REG_BLINK_MASK  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLINK_COUNT = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ON_TIME     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BREAK_TIME  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PRE_TIME    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_POST_TIME   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_MODE = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_INVERT_MASK = 3'd7;

    localparam int RST_BLINK_COUNT = 1;
    localparam int RST_ON_TIME     = 100;
    localparam int RST_BREAK_TIME  = 100;

endpackage

// ===== sv/lbs_cfg_regs.sv =====
// Configuration register file of the LED blink sequencer.
// Depends on lbs_pkg for register indexes and reset values.
module lbs_cfg_regs #(
    parameter int LED_COUNT = 16,
    parameter int TIME_BITS = 16,
    parameter int CFG_W     = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lbs_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]              cfg_wr_data,
    output logic [LED_COUNT-1:0]          blink_mask,
    output logic [lbs_pkg::COUNT_W-1:0]   blink_count,
    output logic [TIME_BITS-1:0]          on_time,
    output logic [TIME_BITS-1:0]          break_time,
    output logic [TIME_BITS-1:0]          pre_time,
    output logic [TIME_BITS-1:0]          post_time,
    output logic                          repeat_mode,
    output logic [LED_COUNT-1:0]          invert_mask
);

    logic [LED_COUNT-1:0]        blink_mask_reg, invert_mask_reg;
    logic [lbs_pkg::COUNT_W-1:0] blink_count_reg;
    logic [TIME_BITS-1:0]        on_time_reg, break_time_reg, pre_time_reg, post_time_reg;
    logic                        repeat_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_mask_reg  <= '0;
            blink_count_reg <= lbs_pkg::COUNT_W'(lbs_pkg::RST_BLINK_COUNT);
            on_time_reg     <= TIME_BITS'(lbs_pkg::RST_ON_TIME);
            break_time_reg  <= TIME_BITS'(lbs_pkg::RST_BREAK_TIME);
            pre_time_reg    <= '0;
            post_time_reg   <= '0;
            repeat_mode_reg <= 1'b0;
            invert_mask_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                lbs_pkg::REG_BLINK_MASK:  blink_mask_reg  <= cfg_wr_data[LED_COUNT-1:0];
                lbs_pkg::REG_BLINK_COUNT: blink_count_reg <= cfg_wr_data[lbs_pkg::COUNT_W-1:0];
                lbs_pkg::REG_ON_TIME:     on_time_reg     <= cfg_wr_data[TIME_BITS-1:0];
                lbs_pkg::REG_BREAK_TIME:  break_time_reg  <= cfg_wr_data[TIME_BITS-1:0];
                lbs_pkg::REG_PRE_TIME:    pre_time_reg    <= cfg_wr_data[TIME_BITS-1:0];
                lbs_pkg::REG_POST_TIME:   post_time_reg   <= cfg_wr_data[TIME_BITS-1:0];
                lbs_pkg::REG_REPEAT_MODE: repeat_mode_reg <= cfg_wr_data[0];
                lbs_pkg::REG_INVERT_MASK: invert_mask_reg <= cfg_wr_data[LED_COUNT-1:0];
                default: ;
            endcase
        end
    end

    assign blink_mask  = blink_mask_reg;
    assign blink_count = blink_count_reg;
    assign on_time     = on_time_reg;
    assign break_time  = break_time_reg;
    assign pre_time    = pre_time_reg;
    assign post_time   = post_time_reg;
    assign repeat_mode = repeat_mode_reg;
    assign invert_mask = invert_mask_reg;

endmodule

// ===== sv/lbs_core.sv =====
// Run state of the LED blink sequencer and the per-request update, including
// the settle chain through zero-length phases. Depends on lbs_pkg.
module lbs_core #(
    parameter int LED_COUNT = 16,
    parameter int TIME_BITS = 16,
    parameter int RES_W     = 21
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [lbs_pkg::KIND_W-1:0]  in_kind,
    input  logic [LED_COUNT-1:0]        in_on_mask,
    input  logic [LED_COUNT-1:0]        in_off_mask,
    input  logic [LED_COUNT-1:0]        blink_mask,
    input  logic [lbs_pkg::COUNT_W-1:0] blink_count,
    input  logic [TIME_BITS-1:0]        on_time,
    input  logic [TIME_BITS-1:0]        break_time,
    input  logic [TIME_BITS-1:0]        pre_time,
    input  logic [TIME_BITS-1:0]        post_time,
    input  logic                        repeat_mode,
    input  logic [LED_COUNT-1:0]        invert_mask,
    output logic [RES_W-1:0]            res_data   // led_drive, busy, phase, start_ignored
);

    typedef struct packed {
        logic [LED_COUNT-1:0]        lit;
        logic [LED_COUNT-1:0]        steady;
        logic [lbs_pkg::PHASE_W-1:0] phase;
        logic [TIME_BITS-1:0]        timer;
        logic [lbs_pkg::COUNT_W-1:0] pulses;
        logic                        stop;
        logic                        rpt;
    } run_st_t;

    localparam int SEEN_W = 1 << lbs_pkg::PHASE_W;

    function automatic run_st_t start_pulse(run_st_t s, logic [LED_COUNT-1:0] bm,
                                            logic [TIME_BITS-1:0] on_t);
        run_st_t r;
        r = s;
        if (r.stop) begin
            r.pulses = '0;
            r.stop   = 1'b0;
        end else if (r.pulses != lbs_pkg::ENDLESS && r.pulses != '0) begin
            r.pulses = r.pulses - 1'b1;
        end
        r.lit   = r.lit | bm;
        r.phase = lbs_pkg::PH_ON;
        r.timer = on_t;
        return r;
    endfunction

    function automatic run_st_t end_phase(run_st_t s, logic [LED_COUNT-1:0] bm,
                                          logic [lbs_pkg::COUNT_W-1:0] cnt,
                                          logic [TIME_BITS-1:0] on_t,
                                          logic [TIME_BITS-1:0] brk_t,
                                          logic [TIME_BITS-1:0] pre_t,
                                          logic [TIME_BITS-1:0] post_t);
        run_st_t r;
        r = s;
        unique case (s.phase)
            lbs_pkg::PH_PRE: begin
                r.pulses = cnt[lbs_pkg::COUNT_W-1] ? lbs_pkg::ENDLESS : cnt;
                if (r.pulses == '0) begin
                    r.phase = lbs_pkg::PH_POST;
                    r.timer = post_t;
                end else begin
                    r = start_pulse(r, bm, on_t);
                end
            end
            lbs_pkg::PH_ON: begin
                r.lit = r.lit & ~bm;
                if (r.pulses != '0 || r.stop) begin
                    r.phase = lbs_pkg::PH_BREAK;
                    r.timer = brk_t;
                end else begin
                    r.phase = lbs_pkg::PH_POST;
                    r.timer = post_t;
                end
            end
            lbs_pkg::PH_BREAK: begin
                r = start_pulse(r, bm, on_t);
            end
            lbs_pkg::PH_POST: begin
                r.lit = r.lit | (bm & r.steady);
                if (r.rpt) begin
                    r.lit   = r.lit & ~bm;
                    r.phase = lbs_pkg::PH_PRE;
                    r.timer = pre_t;
                end else begin
                    r.phase = lbs_pkg::PH_IDLE;
                    r.timer = '0;
                end
            end
            default: begin
                r.phase = lbs_pkg::PH_IDLE;
                r.timer = '0;
            end
        endcase
        return r;
    endfunction

    run_st_t              st_reg, st_next;
    logic                 ignored;
    logic                 chain;
    logic [SEEN_W-1:0]    seen;
    logic [LED_COUNT-1:0] set_on;

    always_comb begin
        st_next = st_reg;
        ignored = 1'b0;
        chain   = 1'b0;
        seen    = '0;
        set_on  = in_on_mask & ~in_off_mask;
        case (in_kind)
            lbs_pkg::KIND_TICK: begin
                if (st_reg.phase != lbs_pkg::PH_IDLE) begin
                    if (st_reg.timer != '0) begin
                        st_next.timer = st_reg.timer - 1'b1;
                    end
                    seen[st_reg.phase] = 1'b1;
                    chain = 1'b1;
                end
            end
            lbs_pkg::KIND_START: begin
                if (st_reg.phase != lbs_pkg::PH_IDLE) begin
                    ignored = 1'b1;
                end else begin
                    st_next.rpt   = repeat_mode;
                    st_next.stop  = 1'b0;
                    st_next.lit   = st_reg.lit & ~blink_mask;
                    st_next.phase = lbs_pkg::PH_PRE;
                    st_next.timer = pre_time;
                    seen[lbs_pkg::PH_PRE] = 1'b1;
                    chain = 1'b1;
                end
            end
            lbs_pkg::KIND_STOP: begin
                if (st_reg.phase == lbs_pkg::PH_ON || st_reg.phase == lbs_pkg::PH_BREAK) begin
                    st_next.stop = 1'b1;
                end
            end
            lbs_pkg::KIND_BRK: begin
                st_next.rpt = 1'b0;
            end
            lbs_pkg::KIND_SET: begin
                st_next.lit    = (st_reg.lit & ~in_off_mask) | set_on;
                st_next.steady = (st_reg.steady & ~in_off_mask) | set_on;
            end
            default: ;
        endcase
        // at most four phase ends: each one enters a phase not yet seen, or stops
        for (int i = 0; i < 4; i++) begin
            if (chain && st_next.phase != lbs_pkg::PH_IDLE && st_next.timer == '0) begin
                st_next = end_phase(st_next, blink_mask, blink_count, on_time,
                                    break_time, pre_time, post_time);
                if (st_next.phase == lbs_pkg::PH_IDLE || seen[st_next.phase]) begin
                    chain = 1'b0;
                end else begin
                    seen[st_next.phase] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else if (in_valid) begin
            st_reg <= st_next;
        end
    end

    assign res_data = {ignored, st_next.phase, (st_next.phase != lbs_pkg::PH_IDLE),
                       st_next.lit ^ invert_mask};

`ifndef SYNTHESIS
    a_idle_timer_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.phase == lbs_pkg::PH_IDLE |-> st_reg.timer == '0)
        else $error("timer nonzero while idle");
    a_pulses_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.pulses <= lbs_pkg::ENDLESS)
        else $error("pulse count out of range");
    a_stop_in_train: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.stop |-> (st_reg.phase == lbs_pkg::PH_ON || st_reg.phase == lbs_pkg::PH_BREAK))
        else $error("stop pending outside the pulse train");
    a_hold_without_request: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid |=> $stable(st_reg))
        else $error("run state changed without a request");
`endif

endmodule

// ===== sv/lbs_out_buf.sv =====
// Two-entry result buffer (output register plus skid register) of the LED blink
// sequencer; it decouples request acceptance from result back-pressure.
module lbs_out_buf #(
    parameter int WIDTH = 21
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg, skid_valid_reg;
    logic [WIDTH-1:0] out_data_reg, skid_data_reg;
    logic             pop;

    assign pop      = out_valid_reg && out_ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= in_valid;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= in_data;
            end else begin
                out_data_reg  <= in_data;
            end
        end else if (in_valid) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");
    a_skid_moves_up: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && skid_valid_reg |=> out_valid_reg && out_data_reg == $past(skid_data_reg))
        else $error("skid entry lost on pop");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready && !skid_valid_reg && !in_valid |=> skid_valid_reg == 1'b0)
        else $error("skid filled without a request");
`endif

endmodule

// ===== sv/led_blink_sequencer.sv =====
// Top level of the LED blink sequencer: config registers, run-state core and
// result buffer. Depends on lbs_pkg, lbs_cfg_regs, lbs_core and lbs_out_buf.
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  tuser: kind; tdata: on_mask, off_mask
//  m_        out        m_tvalid/m_tready  tdata: led_drive; tuser: busy, phase, ignored
//  cfg_      in         cfg_wr_en only     cfg_addr, cfg_wr_data
//
// One request per cycle while s_tready is high; its result is on m_ at the earliest the cycle after acceptance.
// The settle chain through zero-length phases runs in the same cycle as the request.
// Reset (aresetn low, synchronous) clears run state and LEDs, config registers to defaults.
// Two result slots: s_tready drops only when both hold results not yet taken.
module led_blink_sequencer #(
    parameter int LED_COUNT = 16,
    parameter int TIME_BITS = 16,
    localparam int IN_TDATA_W  = ((2 * LED_COUNT + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((LED_COUNT + 7) / 8) * 8,
    localparam int OUT_TUSER_W = lbs_pkg::PHASE_W + 2,
    localparam int CFG_W0      = (LED_COUNT > TIME_BITS) ? LED_COUNT : TIME_BITS,
    localparam int CFG_W       = (CFG_W0 > lbs_pkg::COUNT_W) ? CFG_W0 : lbs_pkg::COUNT_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_TDATA_W-1:0]         s_tdata,   // on_mask, off_mask
    input  logic [lbs_pkg::KIND_W-1:0]    s_tuser,   // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_TDATA_W-1:0]        m_tdata,   // led_drive
    output logic [OUT_TUSER_W-1:0]        m_tuser,   // busy_res, phase, start_ignored
    input  logic                          cfg_wr_en,
    input  logic [lbs_pkg::REG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]              cfg_wr_data
);

    localparam int RES_W       = LED_COUNT + OUT_TUSER_W;

    logic [LED_COUNT-1:0]        blink_mask, invert_mask;
    logic [lbs_pkg::COUNT_W-1:0] blink_count;
    logic [TIME_BITS-1:0]        on_time, break_time, pre_time, post_time;
    logic                        repeat_mode;
    logic                        in_accept;
    logic [RES_W-1:0]            res_data, buf_data;

    assign in_accept = s_tvalid && s_tready;

    lbs_cfg_regs #(
        .LED_COUNT(LED_COUNT),
        .TIME_BITS(TIME_BITS),
        .CFG_W    (CFG_W)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .blink_mask (blink_mask),
        .blink_count(blink_count),
        .on_time    (on_time),
        .break_time (break_time),
        .pre_time   (pre_time),
        .post_time  (post_time),
        .repeat_mode(repeat_mode),
        .invert_mask(invert_mask)
    );

    lbs_core #(
        .LED_COUNT(LED_COUNT),
        .TIME_BITS(TIME_BITS),
        .RES_W    (RES_W)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (in_accept),
        .in_kind    (s_tuser),
        .in_on_mask (s_tdata[LED_COUNT-1:0]),
        .in_off_mask(s_tdata[2*LED_COUNT-1:LED_COUNT]),
        .blink_mask (blink_mask),
        .blink_count(blink_count),
        .on_time    (on_time),
        .break_time (break_time),
        .pre_time   (pre_time),
        .post_time  (post_time),
        .repeat_mode(repeat_mode),
        .invert_mask(invert_mask),
        .res_data   (res_data)
    );

    lbs_out_buf #(
        .WIDTH(RES_W)
    ) u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_accept),
        .in_ready (s_tready),
        .in_data  (res_data),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (buf_data)
    );

    assign m_tdata = OUT_TDATA_W'(buf_data[LED_COUNT-1:0]);
    assign m_tuser = buf_data[RES_W-1:LED_COUNT];

endmodule

// ===== dv/tb_led_blink_sequencer.sv =====
// Self-checking testbench for led_blink_sequencer: a directed table, then random
// event streams under several register settings, checked against table values or a local predictor.
// Depends on lbs_pkg and the led_blink_sequencer RTL.
module tb_led_blink_sequencer;

    localparam int          CYCLE_LIMIT    = 200000;
    localparam int          PHASES         = 8;
    localparam int          ITEMS_PER_PH   = 140;
    localparam int          HOLD_CYCLES    = 300;
    localparam logic [lbs_pkg::KIND_W-1:0] KIND_UNUSED_LO  = 3'd5;
    localparam logic [lbs_pkg::KIND_W-1:0] KIND_UNUSED_MID = 3'd6;
    localparam logic [lbs_pkg::KIND_W-1:0] KIND_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic [15:0]                 led;
        logic                        busy;
        logic [lbs_pkg::PHASE_W-1:0] phase;
        logic                        ign;
    } lamp_res_t;

    typedef struct {
        bit                            is_cfg;
        logic [lbs_pkg::REG_IDX_W-1:0] idx;
        logic [15:0]                   val;
        logic [lbs_pkg::KIND_W-1:0]    kind;
        logic [15:0]                   on_m;
        logic [15:0]                   off_m;
        bit                            chk;
        lamp_res_t                     res;
    } step_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [31:0]                   s_tdata;   // on_mask, off_mask
    logic [lbs_pkg::KIND_W-1:0]    s_tuser;   // kind
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [15:0]                   m_tdata;   // led_drive
    logic [4:0]                    m_tuser;   // busy_res, phase, start_ignored
    logic                          cfg_wr_en;
    logic [lbs_pkg::REG_IDX_W-1:0] cfg_addr;
    logic [15:0]                   cfg_wr_data;

    // predictor copy of registers and run state
    logic [15:0]                 c_mask, c_on, c_break, c_pre, c_post, c_invert;
    logic [lbs_pkg::COUNT_W-1:0] c_count;
    logic                        c_repeat;
    logic [15:0]                 p_steady, p_lit, p_timer;
    logic [lbs_pkg::PHASE_W-1:0] p_phase;
    logic [lbs_pkg::COUNT_W-1:0] p_left;
    logic                        p_stop, p_rep;

    lamp_res_t   pending_leds[$];
    step_row_t   dir_tab[$];
    lamp_res_t   got, want;
    int          mismatches = 0;
    int unsigned cycle_cnt = 0;
    int          tx_idle_pct = 9;
    int          rx_idle_pct = 61;
    int          hold_requests = 0;
    int          holds_done = 0;
    int          rx_hold = 0;

    led_blink_sequencer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic void enter_pre();
        p_lit   = p_lit & ~c_mask;
        p_phase = lbs_pkg::PH_PRE;
        p_timer = c_pre;
    endfunction

    function automatic void enter_post();
        p_phase = lbs_pkg::PH_POST;
        p_timer = c_post;
    endfunction

    function automatic void begin_pulse();
        if (p_stop) begin
            p_left = '0;
            p_stop = 1'b0;
        end else if (p_left != lbs_pkg::ENDLESS && p_left != 0) begin
            p_left = p_left - 1'b1;
        end
        p_lit   = p_lit | c_mask;
        p_phase = lbs_pkg::PH_ON;
        p_timer = c_on;
    endfunction

    function automatic void finish_phase();
        case (p_phase)
            lbs_pkg::PH_PRE: begin
                p_left = (c_count >= lbs_pkg::ENDLESS) ? lbs_pkg::ENDLESS : c_count;
                if (p_left == 0) enter_post();
                else begin_pulse();
            end
            lbs_pkg::PH_ON: begin
                p_lit = p_lit & ~c_mask;
                if (p_left != 0 || p_stop) begin
                    p_phase = lbs_pkg::PH_BREAK;
                    p_timer = c_break;
                end else begin
                    enter_post();
                end
            end
            lbs_pkg::PH_BREAK: begin_pulse();
            lbs_pkg::PH_POST: begin
                p_lit = p_lit | (c_mask & p_steady);
                if (p_rep) begin
                    enter_pre();
                end else begin
                    p_phase = lbs_pkg::PH_IDLE;
                    p_timer = '0;
                end
            end
            default: begin
                p_phase = lbs_pkg::PH_IDLE;
                p_timer = '0;
            end
        endcase
    endfunction

    // walk through zero-length phases; stop on a phase already entered this step
    function automatic void run_settle(input logic [7:0] seen_in);
        logic [7:0] seen;
        seen = seen_in;
        while (p_phase != lbs_pkg::PH_IDLE && p_timer == 0) begin
            finish_phase();
            if (p_phase == lbs_pkg::PH_IDLE) break;
            if (seen[p_phase]) break;
            seen[p_phase] = 1'b1;
        end
    endfunction

    function automatic lamp_res_t predict_leds(input logic [lbs_pkg::KIND_W-1:0] kind,
                                               input logic [15:0] on_m, off_m);
        lamp_res_t r;
        logic      ign;
        ign = 1'b0;
        case (kind)
            lbs_pkg::KIND_TICK: begin
                if (p_phase != lbs_pkg::PH_IDLE) begin
                    if (p_timer != 0) p_timer = p_timer - 1'b1;
                    run_settle(8'b1 << p_phase);
                end
            end
            lbs_pkg::KIND_START: begin
                if (p_phase != lbs_pkg::PH_IDLE) begin
                    ign = 1'b1;
                end else begin
                    p_rep  = c_repeat;
                    p_stop = 1'b0;
                    enter_pre();
                    run_settle(8'b1 << lbs_pkg::PH_PRE);
                end
            end
            lbs_pkg::KIND_STOP: begin
                if (p_phase == lbs_pkg::PH_ON || p_phase == lbs_pkg::PH_BREAK) p_stop = 1'b1;
            end
            lbs_pkg::KIND_BRK: p_rep = 1'b0;
            lbs_pkg::KIND_SET: begin
                p_lit    = (p_lit & ~off_m) | (on_m & ~off_m);
                p_steady = (p_steady & ~off_m) | (on_m & ~off_m);
            end
            default: ;
        endcase
        r.led   = p_lit ^ c_invert;
        r.busy  = (p_phase != lbs_pkg::PH_IDLE);
        r.phase = p_phase;
        r.ign   = ign;
        return r;
    endfunction

    // ---------------- drivers ----------------
    // all driver tasks start and end at a falling edge
    task automatic write_reg(input logic [lbs_pkg::REG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        case (idx)
            lbs_pkg::REG_BLINK_MASK:  c_mask   = val;
            lbs_pkg::REG_BLINK_COUNT: c_count  = val[lbs_pkg::COUNT_W-1:0];
            lbs_pkg::REG_ON_TIME:     c_on     = val;
            lbs_pkg::REG_BREAK_TIME:  c_break  = val;
            lbs_pkg::REG_PRE_TIME:    c_pre    = val;
            lbs_pkg::REG_POST_TIME:   c_post   = val;
            lbs_pkg::REG_REPEAT_MODE: c_repeat = val[0];
            lbs_pkg::REG_INVERT_MASK: c_invert = val;
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic send_req(input logic [lbs_pkg::KIND_W-1:0] kind,
                            input logic [15:0] on_m, off_m,
                            input bit chk, input lamp_res_t typed);
        lamp_res_t r;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {off_m, on_m};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        r = predict_leds(kind, on_m, off_m);
        pending_leds.push_back(chk ? typed : r);
    endtask

    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        while (pending_leds.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic step_row_t row_req(input logic [lbs_pkg::KIND_W-1:0] kind,
                                          input logic [15:0] on_m, off_m);
        step_row_t t;
        t = '{default: '0};
        t.kind  = kind;
        t.on_m  = on_m;
        t.off_m = off_m;
        return t;
    endfunction

    function automatic step_row_t row_chk(input logic [lbs_pkg::KIND_W-1:0] kind,
                                          input logic [15:0] on_m, off_m, led,
                                          input logic busy,
                                          input logic [lbs_pkg::PHASE_W-1:0] ph);
        step_row_t t;
        t = row_req(kind, on_m, off_m);
        t.chk = 1'b1;
        t.res = '{led, busy, ph, 1'b0};
        return t;
    endfunction

    function automatic step_row_t row_cfg(input logic [lbs_pkg::REG_IDX_W-1:0] idx,
                                          input logic [15:0] val);
        step_row_t t;
        t = '{default: '0};
        t.is_cfg = 1'b1;
        t.idx    = idx;
        t.val    = val;
        return t;
    endfunction

    function automatic logic [15:0] pick_mask();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_time();
        case ($urandom_range(0, 9))
            0, 1: return 16'd0;
            2: return 16'($urandom_range(7, 20));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return 16'(lbs_pkg::ENDLESS);
            2: return 16'h01FF;
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    // ---------------- result side ----------------
    always @(negedge aclk) begin
        if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            rx_hold    = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            rx_hold  = rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata, m_tuser[0], m_tuser[3:1], m_tuser[4]};
            if (pending_leds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("cycle %0d: extra result led %h busy %b phase %0d ign %b",
                             cycle_cnt, got.led, got.busy, got.phase, got.ign);
            end else begin
                want = pending_leds.pop_front();
                if (got.led !== want.led || got.busy !== want.busy ||
                    got.phase !== want.phase || got.ign !== want.ign) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("cycle %0d: exp %h/%b/%0d/%b got %h/%b/%0d/%b",
                                 cycle_cnt, want.led, want.busy, want.phase, want.ign,
                                 got.led, got.busy, got.phase, got.ign);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("led_blink_sequencer test failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial begin
        logic [lbs_pkg::KIND_W-1:0] kind;
        logic [15:0]                on_m, off_m;
        int                         r;
        bit                         in_cfg;

        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = lbs_pkg::KIND_TICK;
        cfg_wr_en   = 1'b0;
        cfg_addr    = lbs_pkg::REG_BLINK_MASK;
        cfg_wr_data = '0;
        c_mask = '0; c_count = lbs_pkg::COUNT_W'(lbs_pkg::RST_BLINK_COUNT);
        c_on = 16'(lbs_pkg::RST_ON_TIME); c_break = 16'(lbs_pkg::RST_BREAK_TIME);
        c_pre = '0; c_post = '0; c_repeat = 1'b0; c_invert = '0;
        p_steady = '0; p_lit = '0; p_phase = lbs_pkg::PH_IDLE; p_timer = '0;
        p_left = '0; p_stop = 1'b0; p_rep = 1'b0;
        in_cfg = 1'b0;

        // reset register values, idle block
        dir_tab.push_back(row_chk(lbs_pkg::KIND_TICK, 16'h0000, 16'h0000, 16'h0000, 1'b0,
                                  lbs_pkg::PH_IDLE));
        dir_tab.push_back(row_chk(lbs_pkg::KIND_SET, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0,
                                  lbs_pkg::PH_IDLE));
        dir_tab.push_back(row_chk(lbs_pkg::KIND_SET, 16'hFFFF, 16'h00FF, 16'hFF00, 1'b0,
                                  lbs_pkg::PH_IDLE));
        dir_tab.push_back(row_chk(lbs_pkg::KIND_SET, 16'h0000, 16'hFFFF, 16'h0000, 1'b0,
                                  lbs_pkg::PH_IDLE));
        dir_tab.push_back(row_chk(lbs_pkg::KIND_SET, 16'h0F0F, 16'h0000, 16'h0F0F, 1'b0,
                                  lbs_pkg::PH_IDLE));
        dir_tab.push_back(row_chk(KIND_UNUSED_LO, 16'hFFFF, 16'hFFFF, 16'h0F0F, 1'b0,
                                  lbs_pkg::PH_IDLE));
        dir_tab.push_back(row_chk(KIND_UNUSED_HI, 16'hFFFF, 16'h0000, 16'h0F0F, 1'b0,
                                  lbs_pkg::PH_IDLE));
        dir_tab.push_back(row_chk(lbs_pkg::KIND_STOP, 16'h0000, 16'h0000, 16'h0F0F, 1'b0,
                                  lbs_pkg::PH_IDLE));
        dir_tab.push_back(row_chk(lbs_pkg::KIND_BRK, 16'h0000, 16'h0000, 16'h0F0F, 1'b0,
                                  lbs_pkg::PH_IDLE));
        // short run with repeat, stop and set during post
        dir_tab.push_back(row_cfg(lbs_pkg::REG_BLINK_MASK, 16'h00FF));
        dir_tab.push_back(row_cfg(lbs_pkg::REG_BLINK_COUNT, 16'd2));
        dir_tab.push_back(row_cfg(lbs_pkg::REG_ON_TIME, 16'd1));
        dir_tab.push_back(row_cfg(lbs_pkg::REG_BREAK_TIME, 16'd0));
        dir_tab.push_back(row_cfg(lbs_pkg::REG_PRE_TIME, 16'd1));
        dir_tab.push_back(row_cfg(lbs_pkg::REG_POST_TIME, 16'd2));
        dir_tab.push_back(row_cfg(lbs_pkg::REG_REPEAT_MODE, 16'd1));
        dir_tab.push_back(row_cfg(lbs_pkg::REG_INVERT_MASK, 16'hF000));
        dir_tab.push_back(row_req(lbs_pkg::KIND_START, 16'h0000, 16'h0000));
        dir_tab.push_back(row_req(lbs_pkg::KIND_START, 16'hFFFF, 16'hFFFF));
        dir_tab.push_back(row_req(lbs_pkg::KIND_TICK, 16'h0000, 16'h0000));
        dir_tab.push_back(row_req(lbs_pkg::KIND_STOP, 16'h0000, 16'h0000));
        dir_tab.push_back(row_req(lbs_pkg::KIND_TICK, 16'h0000, 16'h0000));
        dir_tab.push_back(row_req(lbs_pkg::KIND_TICK, 16'h0000, 16'h0000));
        dir_tab.push_back(row_req(lbs_pkg::KIND_TICK, 16'h0000, 16'h0000));
        dir_tab.push_back(row_req(lbs_pkg::KIND_SET, 16'hF000, 16'h0001));
        dir_tab.push_back(row_req(lbs_pkg::KIND_TICK, 16'h0000, 16'h0000));
        dir_tab.push_back(row_req(lbs_pkg::KIND_BRK, 16'h0000, 16'h0000));
        for (int i = 0; i < 5; i++)
            dir_tab.push_back(row_req(lbs_pkg::KIND_TICK, 16'h0000, 16'h0000));
        dir_tab.push_back(row_req(KIND_UNUSED_MID, 16'h1234, 16'h4321));

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                if (!in_cfg) wait_results_done();
                in_cfg = 1'b1;
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                if (in_cfg) cfg_wr_en <= 1'b0;
                in_cfg = 1'b0;
                send_req(dir_tab[i].kind, dir_tab[i].on_m, dir_tab[i].off_m,
                         dir_tab[i].chk, dir_tab[i].res);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            tx_idle_pct = (ph < 3) ? 9 : (ph < 6) ? 61 : 0;
            rx_idle_pct = (ph < 3) ? 61 : (ph < 6) ? 9 : 0;
            wait_results_done();
            if (ph == 0) begin
                // endless pulses with every phase zero-length, repeating
                write_reg(lbs_pkg::REG_BLINK_MASK, 16'hFFFF);
                write_reg(lbs_pkg::REG_BLINK_COUNT, 16'(lbs_pkg::ENDLESS));
                write_reg(lbs_pkg::REG_ON_TIME, 16'd0);
                write_reg(lbs_pkg::REG_BREAK_TIME, 16'd0);
                write_reg(lbs_pkg::REG_PRE_TIME, 16'd0);
                write_reg(lbs_pkg::REG_POST_TIME, 16'd0);
                write_reg(lbs_pkg::REG_REPEAT_MODE, 16'd1);
                write_reg(lbs_pkg::REG_INVERT_MASK, 16'hFFFF);
            end else if (ph == PHASES - 1) begin
                // longest timers last, so no later setting waits them out
                write_reg(lbs_pkg::REG_BLINK_MASK, pick_mask());
                write_reg(lbs_pkg::REG_BLINK_COUNT, 16'h01FF);
                write_reg(lbs_pkg::REG_ON_TIME, 16'hFFFF);
                write_reg(lbs_pkg::REG_BREAK_TIME, 16'hFFFF);
                write_reg(lbs_pkg::REG_PRE_TIME, 16'hFFFF);
                write_reg(lbs_pkg::REG_POST_TIME, 16'hFFFF);
                write_reg(lbs_pkg::REG_REPEAT_MODE, 16'd0);
                write_reg(lbs_pkg::REG_INVERT_MASK, 16'h0000);
            end else begin
                write_reg(lbs_pkg::REG_BLINK_MASK, pick_mask());
                write_reg(lbs_pkg::REG_BLINK_COUNT, pick_count());
                write_reg(lbs_pkg::REG_ON_TIME, pick_time());
                write_reg(lbs_pkg::REG_BREAK_TIME, pick_time());
                write_reg(lbs_pkg::REG_PRE_TIME, pick_time());
                write_reg(lbs_pkg::REG_POST_TIME, pick_time());
                write_reg(lbs_pkg::REG_REPEAT_MODE, 16'($urandom_range(0, 1)));
                write_reg(lbs_pkg::REG_INVERT_MASK, pick_mask());
            end
            cfg_wr_en <= 1'b0;

            for (int n = 0; n < ITEMS_PER_PH; n++) begin
                if (ph == 6 && n == 30) hold_requests++;
                if (ph == 4 && n == 70) wait_results_done();
                r = $urandom_range(0, 99);
                if (r < 55)      kind = lbs_pkg::KIND_TICK;
                else if (r < 67) kind = lbs_pkg::KIND_START;
                else if (r < 75) kind = lbs_pkg::KIND_STOP;
                else if (r < 81) kind = lbs_pkg::KIND_BRK;
                else if (r < 95) kind = lbs_pkg::KIND_SET;
                else kind = lbs_pkg::KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
                on_m = 16'($urandom);
                case ($urandom_range(0, 3))
                    0: off_m = 16'hFFFF;
                    1: off_m = 16'($urandom);
                    default: off_m = 16'($urandom & $urandom & $urandom);
                endcase
                send_req(kind, on_m, off_m, 1'b0, '0);
            end
        end

        wait_results_done();
        if (mismatches == 0 && pending_leds.size() == 0) begin
            $display("led_blink_sequencer test passed");
        end else begin
            $display("led_blink_sequencer test failed");
        end
        $finish;
    end

endmodule
